// ===== sv/gsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared widths, codes, gain table and controller/datapath interface types
// for the gain scheduled PID controller.
// ----------------------------------------------------------------------------
package gsp_pkg;

    localparam int SAMPLE_W = 16;            // Q6.10 samples and setpoint
    localparam int ERR_W    = SAMPLE_W + 1;  // error = setpoint - measurement
    localparam int DIFF_W   = ERR_W + 1;     // error - previous error
    localparam int DT_W     = 16;            // unsigned Q0.16 time step
    localparam int ACC_W    = 32;            // integral and derivative
    localparam int GAIN_W   = 12;            // unsigned Q0.12 gains
    localparam int OUT_W    = 32;            // Q22.10 drive value
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SUM_W    = 48;            // Q.22 weighted sum
    localparam int QUO_W    = DIFF_W - 1 + DT_W;
    localparam int CNT_W    = $clog2(QUO_W);
    localparam int ROW_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [SAMPLE_W-1:0] TARGET_RESET = 16'sd5120;
    localparam logic [DT_W-1:0]            DT_RESET     = 16'd655;

    // A stage write of this code leaves the active gain row unchanged.
    localparam logic [ROW_W-1:0] STAGE_HOLD = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_STAGE = 2'd0,
        CFG_TARGET     = 2'd1,
        CFG_TIME_STEP  = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } t_term;

    typedef enum logic [1:0] {
        MUL_ERR_DT,
        MUL_KP,
        MUL_KI,
        MUL_KD
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     div_start;
        logic     int_upd;
        logic     deriv_upd;
        t_acc_op  acc_op;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_status;

    // Gain schedule: startup, steady state, dynamic response.
    function automatic logic [GAIN_W-1:0] gain_of(input logic [ROW_W-1:0] row,
                                                  input t_term term);
        logic [GAIN_W-1:0] g;
        g = '0;
        case (row)
            2'd1: begin
                case (term)
                    TERM_P:  g = 12'd1229;
                    TERM_I:  g = 12'd205;
                    default: g = 12'd82;
                endcase
            end
            2'd2: begin
                case (term)
                    TERM_P:  g = 12'd3277;
                    TERM_I:  g = 12'd819;
                    default: g = 12'd410;
                endcase
            end
            default: begin
                case (term)
                    TERM_P:  g = 12'd2048;
                    TERM_I:  g = 12'd410;
                    default: g = 12'd205;
                endcase
            end
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

// ===== sv/gsp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gsp_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [gsp_pkg::QUO_W-1:0] i_dividend,
    input  wire logic [gsp_pkg::DT_W-1:0]  i_divisor,
    output logic                           o_busy,
    output logic [gsp_pkg::QUO_W-1:0]      o_quotient
);

    logic                        r_busy;
    logic [gsp_pkg::CNT_W-1:0]   r_count;
    logic [gsp_pkg::DT_W-1:0]    r_rem;
    logic [gsp_pkg::DT_W-1:0]    r_dvs;
    logic [gsp_pkg::QUO_W-1:0]   r_quo;

    logic [gsp_pkg::DT_W:0]      w_shift;
    logic [gsp_pkg::DT_W:0]      w_trial;
    logic                        w_fit;

    assign w_shift = {r_rem, r_quo[gsp_pkg::QUO_W-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};
    assign w_fit   = (w_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_count <= gsp_pkg::CNT_W'(gsp_pkg::QUO_W - 1);
        end else if (r_busy) begin
            if (r_count == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_trial[gsp_pkg::DT_W-1:0] : w_shift[gsp_pkg::DT_W-1:0];
            r_quo <= {r_quo[gsp_pkg::QUO_W-2:0], w_fit};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== sv/gsp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_datapath
// Configuration registers, PID state, shared multiplier, divider, weighted
// sum and output register.
// ----------------------------------------------------------------------------
module gsp_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [gsp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [gsp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic signed [gsp_pkg::SAMPLE_W-1:0] i_measurement,
    input  wire gsp_pkg::t_cmd                       i_cmd,
    output gsp_pkg::t_status                         o_status,
    output logic signed [gsp_pkg::OUT_W-1:0]         o_drive_value,
    output logic                                     o_saturated
);

    localparam int ISUM_W = gsp_pkg::ACC_W + 2;
    localparam int RND_W  = 35;
    localparam int INCR_W = RND_W - 16;
    localparam int ORS_W  = gsp_pkg::SUM_W - 12;

    localparam logic signed [gsp_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(gsp_pkg::ACC_W-1){1'b1}}};
    localparam logic signed [gsp_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(gsp_pkg::ACC_W-1){1'b0}}};
    localparam logic signed [gsp_pkg::OUT_W-1:0] OUT_MAX = {1'b0, {(gsp_pkg::OUT_W-1){1'b1}}};
    localparam logic signed [gsp_pkg::OUT_W-1:0] OUT_MIN = {1'b1, {(gsp_pkg::OUT_W-1){1'b0}}};

    // Configuration.
    logic [gsp_pkg::ROW_W-1:0]            r_row;
    logic signed [gsp_pkg::SAMPLE_W-1:0]  r_target;
    logic [gsp_pkg::DT_W-1:0]             r_dt;

    // State and working registers.
    logic signed [gsp_pkg::ERR_W-1:0]     r_err;
    logic signed [gsp_pkg::ERR_W-1:0]     r_prev;
    logic signed [gsp_pkg::ACC_W-1:0]     r_int;
    logic signed [gsp_pkg::ACC_W-1:0]     r_deriv;
    logic signed [gsp_pkg::PROD_W-1:0]    r_prod;
    logic signed [gsp_pkg::SUM_W-1:0]     r_acc;
    logic                                 r_sat;
    logic signed [gsp_pkg::OUT_W-1:0]     r_drive;
    logic                                 r_sat_out;

    logic signed [gsp_pkg::MUL_A_W-1:0]   w_mul_a;
    logic signed [gsp_pkg::MUL_B_W-1:0]   w_mul_b;
    logic signed [gsp_pkg::PROD_W-1:0]    n_prod;

    logic signed [gsp_pkg::DIFF_W-1:0]    w_diff;
    logic [gsp_pkg::DIFF_W-1:0]           w_mag;
    logic [gsp_pkg::QUO_W-1:0]            w_quo;
    logic                                 w_div_busy;

    logic signed [RND_W-1:0]              w_rnd;
    logic signed [INCR_W-1:0]             w_incr;
    logic signed [ISUM_W-1:0]             w_isum;
    logic signed [gsp_pkg::ACC_W-1:0]     n_int;
    logic                                 w_int_clamp;

    logic signed [gsp_pkg::ACC_W-1:0]     n_deriv;
    logic                                 w_der_clamp;

    logic signed [gsp_pkg::SUM_W-1:0]     w_osum;
    logic signed [ORS_W-1:0]              w_ors;
    logic signed [gsp_pkg::OUT_W-1:0]     n_drive;
    logic                                 w_out_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_target <= gsp_pkg::TARGET_RESET;
            r_dt     <= gsp_pkg::DT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gsp_pkg::CFG_GAIN_STAGE: begin
                    if (i_cfg_data[gsp_pkg::ROW_W-1:0] != gsp_pkg::STAGE_HOLD) begin
                        r_row <= i_cfg_data[gsp_pkg::ROW_W-1:0];
                    end
                end
                gsp_pkg::CFG_TARGET:    r_target <= $signed(i_cfg_data[gsp_pkg::SAMPLE_W-1:0]);
                gsp_pkg::CFG_TIME_STEP: r_dt     <= i_cfg_data[gsp_pkg::DT_W-1:0];
                default: ;
            endcase
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        w_mul_a = gsp_pkg::MUL_A_W'(r_err);
        w_mul_b = '0;
        case (i_cmd.mul_sel)
            gsp_pkg::MUL_ERR_DT: begin
                w_mul_a = gsp_pkg::MUL_A_W'(r_err);
                w_mul_b = $signed({1'b0, r_dt});
            end
            gsp_pkg::MUL_KP: begin
                w_mul_a = gsp_pkg::MUL_A_W'(r_err);
                w_mul_b = $signed(gsp_pkg::MUL_B_W'(gsp_pkg::gain_of(r_row, gsp_pkg::TERM_P)));
            end
            gsp_pkg::MUL_KI: begin
                w_mul_a = r_int;
                w_mul_b = $signed(gsp_pkg::MUL_B_W'(gsp_pkg::gain_of(r_row, gsp_pkg::TERM_I)));
            end
            gsp_pkg::MUL_KD: begin
                w_mul_a = r_deriv;
                w_mul_b = $signed(gsp_pkg::MUL_B_W'(gsp_pkg::gain_of(r_row, gsp_pkg::TERM_D)));
            end
            default: ;
        endcase
    end

    assign n_prod = w_mul_a * w_mul_b;

    // Integral step: round half up of error*dt / 2^16, then saturate.
    assign w_rnd  = r_prod[RND_W-1:0] + RND_W'(32768);
    assign w_incr = w_rnd[RND_W-1:16];
    assign w_isum = ISUM_W'(r_int) + ISUM_W'(w_incr);

    always_comb begin
        w_int_clamp = (w_isum[ISUM_W-1:gsp_pkg::ACC_W-1] != '0) &&
                      (w_isum[ISUM_W-1:gsp_pkg::ACC_W-1] != '1);
        if (w_int_clamp) begin
            n_int = w_isum[ISUM_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            n_int = w_isum[gsp_pkg::ACC_W-1:0];
        end
    end

    // Derivative: |diff| * 2^16 / dt with the sign of diff.
    assign w_diff = gsp_pkg::DIFF_W'(r_err) - gsp_pkg::DIFF_W'(r_prev);
    assign w_mag  = w_diff[gsp_pkg::DIFF_W-1] ? -w_diff : w_diff;

    gsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({w_mag[gsp_pkg::DIFF_W-2:0], {gsp_pkg::DT_W{1'b0}}}),
        .i_divisor  (r_dt),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_deriv     = '0;
        w_der_clamp = 1'b0;
        if (r_dt == '0) begin
            // No time step: the derivative pins to the limit in the direction of change.
            if (w_diff != '0) begin
                w_der_clamp = 1'b1;
                n_deriv     = w_diff[gsp_pkg::DIFF_W-1] ? ACC_MIN : ACC_MAX;
            end
        end else if (w_diff[gsp_pkg::DIFF_W-1]) begin
            if (w_quo[gsp_pkg::QUO_W-1] ||
                (w_quo[gsp_pkg::ACC_W-1] && (w_quo[gsp_pkg::ACC_W-2:0] != '0))) begin
                w_der_clamp = 1'b1;
                n_deriv     = ACC_MIN;
            end else begin
                n_deriv = -$signed(w_quo[gsp_pkg::ACC_W-1:0]);
            end
        end else begin
            if (w_quo[gsp_pkg::QUO_W-1:gsp_pkg::ACC_W-1] != '0) begin
                w_der_clamp = 1'b1;
                n_deriv     = ACC_MAX;
            end else begin
                n_deriv = $signed(w_quo[gsp_pkg::ACC_W-1:0]);
            end
        end
    end

    // Output: round half up of the Q.22 sum to Q.10, then saturate.
    assign w_osum = r_acc + gsp_pkg::SUM_W'(2048);
    assign w_ors  = w_osum[gsp_pkg::SUM_W-1:12];

    always_comb begin
        w_out_clamp = (w_ors[ORS_W-1:gsp_pkg::OUT_W-1] != '0) &&
                      (w_ors[ORS_W-1:gsp_pkg::OUT_W-1] != '1);
        if (w_out_clamp) begin
            n_drive = w_ors[ORS_W-1] ? OUT_MIN : OUT_MAX;
        end else begin
            n_drive = w_ors[gsp_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int  <= '0;
            r_prev <= '0;
        end else begin
            if (i_cmd.int_upd) begin
                r_int <= n_int;
            end
            if (i_cmd.out_load) begin
                r_prev <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err <= gsp_pkg::ERR_W'(r_target) - gsp_pkg::ERR_W'(i_measurement);
            r_sat <= 1'b0;
        end else if ((i_cmd.int_upd && w_int_clamp) || (i_cmd.deriv_upd && w_der_clamp)) begin
            r_sat <= 1'b1;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.deriv_upd) begin
            r_deriv <= n_deriv;
        end
        case (i_cmd.acc_op)
            gsp_pkg::ACC_LOAD: r_acc <= r_prod[gsp_pkg::SUM_W-1:0];
            gsp_pkg::ACC_ADD:  r_acc <= r_acc + r_prod[gsp_pkg::SUM_W-1:0];
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_drive   <= n_drive;
            r_sat_out <= r_sat | w_out_clamp;
        end
    end

    assign o_status.div_busy = w_div_busy;
    assign o_drive_value     = r_drive;
    assign o_saturated       = r_sat_out;

endmodule
`default_nettype wire

// ===== sv/gsp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_ctrl
// Sequencer for one PID step and the request handshakes on both channels.
// ----------------------------------------------------------------------------
module gsp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    input  wire gsp_pkg::t_status i_status,
    output gsp_pkg::t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DT,
        S_INT,
        S_DIV,
        S_DERIV,
        S_MUL_I,
        S_MUL_D,
        S_SUM,
        S_OUT
    } t_state;

    t_state        r_state, n_state;
    logic          r_out_valid, n_out_valid;
    gsp_pkg::t_cmd n_cmd;
    logic          w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        n_cmd       = '0;
        n_cmd.mul_sel = gsp_pkg::MUL_ERR_DT;
        n_cmd.acc_op  = gsp_pkg::ACC_HOLD;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd.load = 1'b1;
                    n_state    = S_MUL_DT;
                end
            end
            S_MUL_DT: begin
                n_cmd.mul_en    = 1'b1;
                n_cmd.mul_sel   = gsp_pkg::MUL_ERR_DT;
                n_cmd.div_start = 1'b1;
                n_state         = S_INT;
            end
            S_INT: begin
                n_cmd.int_upd = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_DERIV;
                end
            end
            S_DERIV: begin
                n_cmd.deriv_upd = 1'b1;
                n_cmd.mul_en    = 1'b1;
                n_cmd.mul_sel   = gsp_pkg::MUL_KP;
                n_state         = S_MUL_I;
            end
            S_MUL_I: begin
                n_cmd.acc_op  = gsp_pkg::ACC_LOAD;
                n_cmd.mul_en  = 1'b1;
                n_cmd.mul_sel = gsp_pkg::MUL_KI;
                n_state       = S_MUL_D;
            end
            S_MUL_D: begin
                n_cmd.acc_op  = gsp_pkg::ACC_ADD;
                n_cmd.mul_en  = 1'b1;
                n_cmd.mul_sel = gsp_pkg::MUL_KD;
                n_state       = S_SUM;
            end
            S_SUM: begin
                n_cmd.acc_op = gsp_pkg::ACC_ADD;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // The result waits here until the output register is free.
                if (w_out_free) begin
                    n_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd   = n_cmd;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_cmd.out_load |-> w_out_free)
        else $error("output register loaded while a result is still held");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_MUL_DT))
        else $error("accepted request did not start the sequence");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_cmd.div_start |=> i_status.div_busy)
        else $error("divider did not start");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_status.div_busy) |=> (r_state == S_DERIV))
        else $error("sequencer missed divider completion");

endmodule
`default_nettype wire

// ===== sv/gain_scheduled_pid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gain_scheduled_pid
// PID controller with a three-row gain schedule and saturating fixed point.
// ----------------------------------------------------------------------------
// Each measurement request is accepted in idle and then runs through the
// error*dt product, the integral update, the bit-serial divider that forms
// the derivative, the gain products on the shared 32x17 multiplier, the
// weighted sum and the output rounding; the next request is accepted back
// in idle. A finished result sits in an output register, so a new
// measurement is taken while the previous result waits; a step only stalls
// at its end if that register is still occupied. Configuration writes take
// effect at once and are meant for idle periods. There is no clearing pass.
module gain_scheduled_pid (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [gsp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [gsp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [gsp_pkg::SAMPLE_W-1:0] i_measurement,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [gsp_pkg::OUT_W-1:0]         o_drive_value,
    output logic                                     o_saturated
);

    gsp_pkg::t_cmd    w_cmd;
    gsp_pkg::t_status w_status;

    gsp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    gsp_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_measurement (i_measurement),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_drive_value (o_drive_value),
        .o_saturated   (o_saturated)
    );

endmodule
`default_nettype wire
